@@ src/type1_charstring_interpreter_core_defines.svh @@
// assertion macros used by the charstring interpreter core
`ifndef TYPE1_CHARSTRING_INTERPRETER_CORE_DEFINES_SVH
`define TYPE1_CHARSTRING_INTERPRETER_CORE_DEFINES_SVH

// property checked at every rising edge outside reset
`define TCI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define TCI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tci_pkg.sv @@
// shared constants, types and helper functions of the charstring interpreter
package tci_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int OPND_W      = 48;
  localparam int COORD_W     = 32;
  localparam int SCALE_W     = 24;
  localparam int SUBR_W      = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h100000;

  // result command codes
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_MOVE      = 3'd0;
  localparam cmd_t CMD_LINE      = 3'd1;
  localparam cmd_t CMD_CURVE     = 3'd2;
  localparam cmd_t CMD_CLOSE     = 3'd3;
  localparam cmd_t CMD_SUBR      = 3'd4;
  localparam cmd_t CMD_SBW       = 3'd5;
  localparam cmd_t CMD_STACK_ERR = 3'd6;
  localparam cmd_t CMD_DIV_ZERO  = 3'd7;

  // charstring opcodes
  localparam logic [7:0] OPC_VMOVETO    = 8'd4;
  localparam logic [7:0] OPC_RLINETO    = 8'd5;
  localparam logic [7:0] OPC_HLINETO    = 8'd6;
  localparam logic [7:0] OPC_VLINETO    = 8'd7;
  localparam logic [7:0] OPC_RRCURVETO  = 8'd8;
  localparam logic [7:0] OPC_CLOSEPATH  = 8'd9;
  localparam logic [7:0] OPC_CALLSUBR   = 8'd10;
  localparam logic [7:0] OPC_ESCAPE     = 8'd12;
  localparam logic [7:0] OPC_HSBW       = 8'd13;
  localparam logic [7:0] OPC_RMOVETO    = 8'd21;
  localparam logic [7:0] OPC_HMOVETO    = 8'd22;
  localparam logic [7:0] OPC_VHCURVETO  = 8'd30;
  localparam logic [7:0] OPC_HVCURVETO  = 8'd31;
  localparam logic [7:0] ESC_SBW        = 8'd7;
  localparam logic [7:0] ESC_DIV        = 8'd12;

  // number encoding
  localparam logic [7:0]  NUM_MIN       = 8'd32;
  localparam logic [7:0]  NUM_SHORT_MAX = 8'd246;
  localparam logic [7:0]  NUM_POS_BASE  = 8'd247;
  localparam logic [7:0]  NUM_NEG_BASE  = 8'd251;
  localparam logic [7:0]  NUM_LONG      = 8'd255;
  localparam logic [31:0] NUM_BIAS      = 32'd139;
  localparam logic [31:0] NUM_OFFSET    = 32'd108;
  localparam logic [2:0]  LONG_BYTES    = 3'd4;

  typedef enum logic [3:0] {
    K_NONE, K_MOVE, K_LINE, K_CURVE, K_CLOSE, K_SUBR, K_HSBW, K_SBW, K_DIV
  } op_kind_t;

  // need: operands popped, scl: operands get scaled,
  // dmap: delta slot for each operand, bottom operand first
  typedef struct packed {
    op_kind_t        kind;
    logic [2:0]      need;
    logic            scl;
    logic [5:0][2:0] dmap;
  } op_info_t;

  function automatic op_info_t op_decode(input logic [7:0] b, input logic esc);
    op_info_t info;
    info = '0;
    info.kind = K_NONE;
    if (esc) begin
      unique case (b)
        ESC_SBW: begin
          info.kind = K_SBW; info.need = 3'd4; info.scl = 1'b1;
          info.dmap[0] = 3'd0; info.dmap[1] = 3'd1;
          info.dmap[2] = 3'd2; info.dmap[3] = 3'd3;
        end
        ESC_DIV: begin
          info.kind = K_DIV; info.need = 3'd2;
        end
        default: ;
      endcase
    end else begin
      unique case (b)
        OPC_VMOVETO, OPC_VLINETO: begin
          info.kind = (b == OPC_VMOVETO) ? K_MOVE : K_LINE;
          info.need = 3'd1; info.scl = 1'b1; info.dmap[0] = 3'd1;
        end
        OPC_HMOVETO, OPC_HLINETO: begin
          info.kind = (b == OPC_HMOVETO) ? K_MOVE : K_LINE;
          info.need = 3'd1; info.scl = 1'b1; info.dmap[0] = 3'd0;
        end
        OPC_RMOVETO, OPC_RLINETO: begin
          info.kind = (b == OPC_RMOVETO) ? K_MOVE : K_LINE;
          info.need = 3'd2; info.scl = 1'b1;
          info.dmap[0] = 3'd0; info.dmap[1] = 3'd1;
        end
        OPC_RRCURVETO: begin
          info.kind = K_CURVE; info.need = 3'd6; info.scl = 1'b1;
          info.dmap[0] = 3'd0; info.dmap[1] = 3'd1; info.dmap[2] = 3'd2;
          info.dmap[3] = 3'd3; info.dmap[4] = 3'd4; info.dmap[5] = 3'd5;
        end
        OPC_VHCURVETO: begin
          info.kind = K_CURVE; info.need = 3'd4; info.scl = 1'b1;
          info.dmap[0] = 3'd1; info.dmap[1] = 3'd2;
          info.dmap[2] = 3'd3; info.dmap[3] = 3'd4;
        end
        OPC_HVCURVETO: begin
          info.kind = K_CURVE; info.need = 3'd4; info.scl = 1'b1;
          info.dmap[0] = 3'd0; info.dmap[1] = 3'd2;
          info.dmap[2] = 3'd3; info.dmap[3] = 3'd5;
        end
        OPC_CLOSEPATH: info.kind = K_CLOSE;
        OPC_CALLSUBR: begin
          info.kind = K_SUBR; info.need = 3'd1;
        end
        OPC_HSBW: begin
          info.kind = K_HSBW; info.need = 3'd2; info.scl = 1'b1;
          info.dmap[0] = 3'd0; info.dmap[1] = 3'd2;
        end
        default: ;
      endcase
    end
    return info;
  endfunction

  function automatic logic signed [COORD_W-1:0] add_sat32(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

@@ src/tci_ram.sv @@
// generic single-write, single-read ram with registered read data
module tci_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tci_scaler.sv @@
// multi-cycle operand scaler: |op| * scale / 2^20, signed saturation to 32 bits
module tci_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [tci_pkg::OPND_W-1:0]    operand,
  input  logic [tci_pkg::SCALE_W-1:0]          scale,
  output logic                                 done,
  output logic signed [tci_pkg::COORD_W-1:0]   result
);
  import tci_pkg::*;

  localparam int FRAC   = 20;
  localparam int HI_W   = OPND_W - FRAC + SCALE_W;
  localparam int LO_W   = FRAC + SCALE_W;
  localparam int SUM_W  = HI_W + 1;

  logic              busy;
  logic [1:0]        phase;
  logic              neg;
  logic [OPND_W-1:0] mag;
  logic [HI_W-1:0]   hi_p;
  logic [LO_W-1:0]   lo_full;
  logic [SCALE_W-1:0] lo_p;
  logic [SUM_W-1:0]  sum;

  assign lo_full = LO_W'(mag[FRAC-1:0]) * LO_W'(scale);
  assign sum     = SUM_W'(hi_p) + SUM_W'(lo_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
        neg   <= operand[OPND_W-1];
        mag   <= operand[OPND_W-1] ? OPND_W'(-operand) : OPND_W'(operand);
      end else if (busy) begin
        case (phase)
          2'd0: begin
            hi_p  <= HI_W'(mag[OPND_W-1:FRAC]) * HI_W'(scale);
            phase <= 2'd1;
          end
          2'd1: begin
            lo_p  <= lo_full[LO_W-1:FRAC];
            phase <= 2'd2;
          end
          default: begin
            if (neg) begin
              result <= (sum > SUM_W'(33'h080000000)) ? 32'sh80000000
                                                      : -$signed(sum[COORD_W-1:0]);
            end else begin
              result <= (sum > SUM_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                     : $signed(sum[COORD_W-1:0]);
            end
            done  <= 1'b1;
            busy  <= 1'b0;
            phase <= 2'd0;
          end
        endcase
      end
    end
  end

endmodule

@@ src/tci_divider.sv @@
// bit-serial Q32.16 divider, truncating toward zero with 48-bit saturation
module tci_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tci_pkg::OPND_W-1:0] num,
  input  logic signed [tci_pkg::OPND_W-1:0] den,
  output logic                              done,
  output logic signed [tci_pkg::OPND_W-1:0] quot
);
  import tci_pkg::*;

  localparam int DVD_W = OPND_W + 16;
  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic                busy;
  logic                neg;
  logic [CNT_BITS-1:0] steps;
  logic [OPND_W-1:0]   den_mag;
  logic [DVD_W-1:0]    dvd;
  logic [DVD_W-1:0]    q;
  logic [OPND_W-1:0]   rem;
  logic [OPND_W:0]     trial;
  logic [OPND_W-1:0]   num_mag;

  assign trial   = {rem, dvd[DVD_W-1]};
  assign num_mag = num[OPND_W-1] ? OPND_W'(-num) : OPND_W'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        steps   <= '0;
        neg     <= num[OPND_W-1] ^ den[OPND_W-1];
        den_mag <= den[OPND_W-1] ? OPND_W'(-den) : OPND_W'(den);
        dvd     <= {num_mag, 16'd0};
        q       <= '0;
        rem     <= '0;
      end else if (busy) begin
        if (steps != CNT_BITS'(DVD_W)) begin
          // one restoring step per cycle
          if (trial >= {1'b0, den_mag}) begin
            rem <= OPND_W'(trial - {1'b0, den_mag});
            q   <= {q[DVD_W-2:0], 1'b1};
          end else begin
            rem <= trial[OPND_W-1:0];
            q   <= {q[DVD_W-2:0], 1'b0};
          end
          dvd   <= {dvd[DVD_W-2:0], 1'b0};
          steps <= steps + 1'b1;
        end else begin
          if (neg) begin
            quot <= (q > DVD_W'({1'b1, {(OPND_W-1){1'b0}}})) ?
                    {1'b1, {(OPND_W-1){1'b0}}} : -$signed(q[OPND_W-1:0]);
          end else begin
            quot <= (q > DVD_W'({1'b0, {(OPND_W-1){1'b1}}})) ?
                    {1'b0, {(OPND_W-1){1'b1}}} : $signed(q[OPND_W-1:0]);
          end
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ src/type1_charstring_interpreter_core.sv @@
// top level of the type 1 charstring interpreter
//
// usage: decrypted charstring bytes enter on the input channel (code_byte,
// glyph_start with in_valid/in_stall); path, metric, subroutine and error
// results leave on the output channel (command and point fields with
// out_valid/out_stall). glyph_start clears stack, pen and any number or
// escape in progress before its byte is handled. the scale register is
// written through cfg_wr_en/cfg_wr_data; write it only while the block
// is idle, the block itself does not enforce this. the operand stack
// lives in a 1-read 1-write ram; operators read their operands one at a
// time via S_RD and S_CAP, and the shared scaler takes one at a time.
// number bytes and ignored opcodes are taken in S_IDLE without raising
// in_stall unless the stack overflows; an operator holds in_stall while
// it reads, scales and executes, and div holds it while the bit-serial
// divider runs. when the receiver stalls, the result waits in the output
// register and the block keeps taking bytes; apart from operators, it
// holds in_stall only when a second request is ready and the first is
// not taken. reset (synchronous, active high) empties the stack, zeroes
// the pen and sets scale to 1.0; stack contents need no clearing.
`include "type1_charstring_interpreter_core_defines.svh"
module type1_charstring_interpreter_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [tci_pkg::SCALE_W-1:0]           cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            code_byte,
  input  logic                                  glyph_start,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            command,
  output logic signed [tci_pkg::COORD_W-1:0]    point_x1,
  output logic signed [tci_pkg::COORD_W-1:0]    point_y1,
  output logic signed [tci_pkg::COORD_W-1:0]    point_x2,
  output logic signed [tci_pkg::COORD_W-1:0]    point_y2,
  output logic signed [tci_pkg::COORD_W-1:0]    point_x3,
  output logic signed [tci_pkg::COORD_W-1:0]    point_y3,
  output logic [tci_pkg::SUBR_W-1:0]            subroutine_index,
  output logic signed [tci_pkg::COORD_W-1:0]    advance_x,
  output logic signed [tci_pkg::COORD_W-1:0]    advance_y
);
  import tci_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CAP  = 7'b0000100,
    S_SCL  = 7'b0001000,
    S_EXEC = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  // architectural state
  logic [SCALE_W-1:0]        scale;
  logic [CNT_W-1:0]          count;
  logic signed [COORD_W-1:0] pen_x;
  logic signed [COORD_W-1:0] pen_y;
  logic [7:0]                number_prefix;
  logic [2:0]                bytes_pending;
  logic                      escape_pending;
  logic [31:0]               number_gather;

  // operator work registers
  op_info_t                  op;
  logic [CNT_W-1:0]          base;
  logic [2:0]                idx;
  logic [1:0]                step;
  logic signed [COORD_W-1:0] dv [6];
  logic [OPND_W-1:0]         raw0;
  logic [OPND_W-1:0]         raw1;

  // request being assembled
  cmd_t                      w_cmd;
  logic signed [COORD_W-1:0] w_x1, w_y1, w_x2, w_y2, w_x3, w_y3, w_ax, w_ay;
  logic [SUBR_W-1:0]         w_sub;

  // effective state after an optional glyph clear
  logic [CNT_W-1:0] eff_count;
  logic [2:0]       eff_pending;
  logic [7:0]       eff_prefix;
  logic [31:0]      eff_gather;
  logic             eff_esc;

  // byte decode
  logic             d_push;
  logic [31:0]      d_val;
  logic [2:0]       d_pending;
  logic [7:0]       d_prefix;
  logic [31:0]      d_gather;
  logic             d_esc;
  op_info_t         d_info;
  logic [7:0]       two_hi;
  logic [31:0]      two_mag;
  logic             push_ok;
  logic             accept;

  // stack ram
  logic              ram_we;
  logic [SP_W-1:0]   ram_waddr;
  logic [OPND_W-1:0] ram_wdata;
  logic [SP_W-1:0]   ram_raddr;
  logic [OPND_W-1:0] ram_rdata;

  // arithmetic units
  logic                      scl_start;
  logic                      scl_done;
  logic signed [COORD_W-1:0] scl_result;
  logic                      div_start;
  logic                      div_done;
  logic signed [OPND_W-1:0]  div_quot;
  logic                      last_opnd;
  logic                      div_by_zero;

  // pen / curve adder, one pair per step
  logic signed [COORD_W-1:0] add_ax, add_bx, add_ay, add_by, sum_x, sum_y;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign eff_count   = glyph_start ? '0 : count;
  assign eff_pending = glyph_start ? 3'd0 : bytes_pending;
  assign eff_prefix  = glyph_start ? 8'd0 : number_prefix;
  assign eff_gather  = glyph_start ? 32'd0 : number_gather;
  assign eff_esc     = glyph_start ? 1'b0 : escape_pending;

  assign two_hi  = (eff_prefix < NUM_NEG_BASE) ? eff_prefix - NUM_POS_BASE
                                               : eff_prefix - NUM_NEG_BASE;
  assign two_mag = {22'd0, two_hi[1:0], 8'd0} + NUM_OFFSET + {24'd0, code_byte};
  assign push_ok = eff_count < CNT_W'(STACK_DEPTH);

  // number assembly and opcode decode
  always_comb begin
    d_push    = 1'b0;
    d_val     = 32'd0;
    d_pending = eff_pending;
    d_prefix  = eff_prefix;
    d_gather  = eff_gather;
    d_esc     = eff_esc;
    d_info    = op_decode(8'd0, 1'b1);
    if (eff_pending != 3'd0) begin
      if (eff_prefix == NUM_LONG) begin
        d_gather  = {eff_gather[23:0], code_byte};
        d_pending = eff_pending - 3'd1;
        if (eff_pending == 3'd1) begin
          d_push = 1'b1;
          d_val  = d_gather;
        end
      end else begin
        d_pending = 3'd0;
        d_push    = 1'b1;
        d_val     = (eff_prefix < NUM_NEG_BASE) ? two_mag : 32'(-two_mag);
      end
    end else if (eff_esc) begin
      d_esc  = 1'b0;
      d_info = op_decode(code_byte, 1'b1);
    end else if (code_byte >= NUM_MIN) begin
      if (code_byte <= NUM_SHORT_MAX) begin
        d_push = 1'b1;
        d_val  = {24'd0, code_byte} - NUM_BIAS;
      end else begin
        d_prefix  = code_byte;
        d_pending = (code_byte == NUM_LONG) ? LONG_BYTES : 3'd1;
        d_gather  = 32'd0;
      end
    end else begin
      d_info = op_decode(code_byte, 1'b0);
      if (code_byte == OPC_ESCAPE) begin
        d_esc = 1'b1;
      end
    end
  end

  assign div_by_zero = (raw1 == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base[SP_W-1:0];
    ram_wdata = '0;
    if (state == S_IDLE) begin
      ram_we    = accept && d_push && push_ok;
      ram_waddr = eff_count[SP_W-1:0];
      ram_wdata = {d_val, 16'd0};
    end else if (state == S_EXEC) begin
      // divide by zero leaves a zero on the stack
      ram_we = (op.kind == K_DIV) && div_by_zero;
    end else if (state == S_DIV) begin
      ram_we    = div_done;
      ram_wdata = div_quot;
    end
  end

  assign ram_raddr = SP_W'(base + CNT_W'(idx));
  assign scl_start = (state == S_CAP) && op.scl;
  assign div_start = (state == S_EXEC) && (op.kind == K_DIV) && !div_by_zero;
  assign last_opnd = (idx == op.need - 3'd1);

  always_comb begin
    case (step)
      2'd0: begin
        add_ax = pen_x; add_ay = pen_y; add_bx = dv[0]; add_by = dv[1];
      end
      2'd1: begin
        add_ax = w_x1;  add_ay = w_y1;  add_bx = dv[2]; add_by = dv[3];
      end
      default: begin
        add_ax = w_x2;  add_ay = w_y2;  add_bx = dv[4]; add_by = dv[5];
      end
    endcase
  end

  assign sum_x = add_sat32(add_ax, add_bx);
  assign sum_y = add_sat32(add_ay, add_by);

  tci_ram #(
    .WIDTH (OPND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tci_scaler u_scaler (
    .clk     (clk),
    .rst     (rst),
    .start   (scl_start),
    .operand (ram_rdata),
    .scale   (scale),
    .done    (scl_done),
    .result  (scl_result)
  );

  tci_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (raw0),
    .den   (raw1),
    .done  (div_done),
    .quot  (div_quot)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      pen_x          <= '0;
      pen_y          <= '0;
      number_prefix  <= '0;
      bytes_pending  <= '0;
      escape_pending <= 1'b0;
      number_gather  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count          <= eff_count;
            number_prefix  <= d_prefix;
            bytes_pending  <= d_pending;
            number_gather  <= d_gather;
            escape_pending <= d_esc;
            if (glyph_start) begin
              pen_x <= '0;
              pen_y <= '0;
            end
            // start every request from all-zero fields and a stack-error command
            w_cmd <= CMD_STACK_ERR;
            w_x1 <= '0; w_y1 <= '0; w_x2 <= '0; w_y2 <= '0;
            w_x3 <= '0; w_y3 <= '0; w_ax <= '0; w_ay <= '0;
            w_sub <= '0;
            for (int i = 0; i < 6; i++) begin
              dv[i] <= '0;
            end
            op   <= d_info;
            idx  <= 3'd0;
            step <= 2'd0;
            if (d_push) begin
              if (push_ok) begin
                count <= eff_count + 1'b1;
              end else begin
                // overflow: number dropped
                state <= S_OUT;
              end
            end else if (d_info.kind != K_NONE) begin
              if (CNT_W'(d_info.need) > eff_count) begin
                // underflow empties the stack
                count <= '0;
                state <= S_OUT;
              end else if (d_info.kind == K_CLOSE) begin
                w_cmd <= CMD_CLOSE;
                state <= S_OUT;
              end else begin
                base  <= eff_count - CNT_W'(d_info.need);
                count <= eff_count - CNT_W'(d_info.need);
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          state <= S_CAP;
        end
        S_CAP: begin
          if (op.scl) begin
            state <= S_SCL;
          end else begin
            if (idx == 3'd0) begin
              raw0 <= ram_rdata;
            end else begin
              raw1 <= ram_rdata;
            end
            idx   <= idx + 3'd1;
            state <= last_opnd ? S_EXEC : S_RD;
          end
        end
        S_SCL: begin
          if (scl_done) begin
            dv[op.dmap[idx]] <= scl_result;
            idx   <= idx + 3'd1;
            state <= last_opnd ? S_EXEC : S_RD;
          end
        end
        S_EXEC: begin
          case (op.kind)
            K_MOVE, K_LINE: begin
              pen_x <= sum_x;
              pen_y <= sum_y;
              w_x1  <= sum_x;
              w_y1  <= sum_y;
              w_cmd <= (op.kind == K_MOVE) ? CMD_MOVE : CMD_LINE;
              state <= S_OUT;
            end
            K_CURVE: begin
              case (step)
                2'd0: begin
                  w_x1 <= sum_x; w_y1 <= sum_y; step <= 2'd1;
                end
                2'd1: begin
                  w_x2 <= sum_x; w_y2 <= sum_y; step <= 2'd2;
                end
                default: begin
                  w_x3  <= sum_x;
                  w_y3  <= sum_y;
                  pen_x <= sum_x;
                  pen_y <= sum_y;
                  w_cmd <= CMD_CURVE;
                  state <= S_OUT;
                end
              endcase
            end
            K_HSBW, K_SBW: begin
              pen_x <= dv[0];
              pen_y <= dv[1];
              w_x1  <= dv[0];
              w_y1  <= dv[1];
              w_ax  <= dv[2];
              w_ay  <= dv[3];
              w_cmd <= CMD_SBW;
              state <= S_OUT;
            end
            K_SUBR: begin
              w_sub <= raw0[31:16];
              w_cmd <= CMD_SUBR;
              state <= S_OUT;
            end
            K_DIV: begin
              if (div_by_zero) begin
                count <= base + 1'b1;
                w_cmd <= CMD_DIV_ZERO;
                state <= S_OUT;
              end else begin
                state <= S_DIV;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            count <= base + 1'b1;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output valid: set when a request loads, cleared when it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      command          <= w_cmd;
      point_x1         <= w_x1;
      point_y1         <= w_y1;
      point_x2         <= w_x2;
      point_y2         <= w_y2;
      point_x3         <= w_x3;
      point_y3         <= w_y3;
      subroutine_index <= w_sub;
      advance_x        <= w_ax;
      advance_y        <= w_ay;
    end
  end

  `TCI_ASSERT(a_count_range, clk, rst, count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `TCI_ASSERT(a_scl_done, clk, rst, scl_done |-> state == S_SCL, "scaler result with no reader")
  `TCI_ASSERT(a_ram_we, clk, rst, ram_we |-> (state == S_IDLE || state == S_EXEC || state == S_DIV), "stack write outside push or div")
  `TCI_ASSERT(a_out_hold, clk, rst, (state == S_OUT && out_valid && out_stall) |=> state == S_OUT, "request lost while output stalled")

endmodule
